// ===== rtl/core/gps_date_to_unix_timestamp_assert.svh =====
// Assertion macros shared by the checker.
`ifndef GPS_DATE_TO_UNIX_TIMESTAMP_ASSERT_SVH
`define GPS_DATE_TO_UNIX_TIMESTAMP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define GDUT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define GDUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gdut_pkg.sv =====
`timescale 1ns / 1ps
package gdut_pkg;

    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    // 1/100 reciprocal, exact for the 13-bit year range used here
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;
    localparam logic [12:0] YEAR_OFFSET  = 13'd400;
    // 719468 epoch shift + 146097 for the 400-year offset + 1 for 1-based day
    localparam logic [31:0] DAY_BIAS     = 32'd865566;
    localparam logic [31:0] SEC_PER_DAY  = 32'd86400;

    localparam int CAL_LAT = 4;
    localparam int DIV_LAT = 34;

    typedef struct packed {
        logic [31:0] ns;
        logic        valid;
    } t_frac;

    // Days before the month, March-based year; month 0 and 13..15 wrap.
    function automatic logic [8:0] month_days(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd0:    d = 9'd275;
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd13:   d = 9'd306;
            4'd14:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Year of the March-based calendar, offset by 400.
    function automatic logic [12:0] cal_year(input logic [11:0] year, input logic [3:0] month);
        logic [12:0] y;
        y = 13'(year) + YEAR_OFFSET;
        case (month)
            4'd0, 4'd1, 4'd2: y = y - 13'd1;
            4'd15:            y = y + 13'd1;
            default:          y = y;
        endcase
        return y;
    endfunction

endpackage

// ===== rtl/core/gdut_cal.sv =====
`timescale 1ns / 1ps
module gdut_cal import gdut_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_second,
    input  logic [7:0]  i_leap,
    input  logic [7:0]  i_minute,
    input  logic [7:0]  i_hour,
    input  logic [7:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [11:0] i_year,
    output logic [31:0] o_secs,
    output logic [63:0] o_secs_ns
);

    logic [12:0] r_y;
    logic [25:0] r_m100;
    logic [23:0] r_m400;
    logic [9:0]  r_doy;
    logic [31:0] r_hms;
    logic [31:0] r_days;
    logic [31:0] r_hms2;
    logic [31:0] r_secs;
    logic [31:0] r_secs4;
    logic [63:0] r_sns;
    logic [12:0] n_y;

    assign n_y = cal_year(i_year, i_month);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: year, reciprocal products, day of year, time of day
            r_y    <= n_y;
            r_m100 <= 26'(n_y) * 26'(RECIP_100);
            r_m400 <= 24'(n_y[12:2]) * 24'(RECIP_100);
            r_doy  <= 10'(month_days(i_month)) + 10'(i_day);
            r_hms  <= 32'(i_hour) * 32'd3600 + 32'(i_minute) * 32'd60
                    + 32'(i_second) - 32'(i_leap);
            // stage 2: day count, all mod 2^32
            r_days <= 32'(r_y) * 32'd365 + 32'(r_y[12:2])
                    - 32'(r_m100[25:RECIP_SHIFT]) + 32'(r_m400[23:RECIP_SHIFT])
                    + 32'(r_doy) - DAY_BIAS;
            r_hms2 <= r_hms;
            // stage 3: seconds
            r_secs <= r_days * SEC_PER_DAY + r_hms2;
            // stage 4: seconds in ns
            r_secs4 <= r_secs;
            r_sns   <= 64'(r_secs) * 64'(NS_PER_SEC);
        end
    end

    assign o_secs    = r_secs4;
    assign o_secs_ns = r_sns;

endmodule

// ===== rtl/core/gdut_div.sv =====
`timescale 1ns / 1ps
module gdut_div import gdut_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_ctd,
    input  logic [31:0] i_ctp,
    output t_frac       o_frac
);

    localparam int STEPS = 32;

    logic [61:0] r_n;
    logic [30:0] r_p;

    logic [30:0] r_rem  [0:STEPS];
    logic [31:0] r_low  [0:STEPS];
    logic [30:0] r_pd   [0:STEPS];
    logic [31:0] r_q    [0:STEPS];
    logic        r_sat  [0:STEPS];
    logic        r_zero [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= 62'(i_ctd) * 62'(NS_PER_SEC);
            r_p <= i_ctp[30:0];
            // quotient overflows 32 bits exactly when the upper half reaches P
            r_rem[0]  <= 31'(r_n[61:32]);
            r_low[0]  <= r_n[31:0];
            r_pd[0]   <= r_p;
            r_q[0]    <= '0;
            r_sat[0]  <= (31'(r_n[61:32]) >= r_p);
            r_zero[0] <= (r_p == '0);
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [31:0] t;
        logic [31:0] diff;
        logic        ge;
        assign t    = {r_rem[k], r_low[k][31]};
        assign diff = t - {1'b0, r_pd[k]};
        assign ge   = (t >= {1'b0, r_pd[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? diff[30:0] : t[30:0];
                r_low[k+1]  <= {r_low[k][30:0], 1'b0};
                r_pd[k+1]   <= r_pd[k];
                r_q[k+1]    <= {r_q[k][30:0], ge};
                r_sat[k+1]  <= r_sat[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    always_comb begin
        o_frac.valid = !r_zero[STEPS];
        if (r_zero[STEPS]) begin
            o_frac.ns = '0;
        end else if (r_sat[STEPS]) begin
            o_frac.ns = '1;
        end else begin
            o_frac.ns = r_q[STEPS];
        end
    end

endmodule

// ===== rtl/core/gps_date_to_unix_timestamp.sv =====
`timescale 1ns / 1ps
// GPS event time stamp to Unix time. Each input item carries one event's
// GPS calendar fields (leap count subtracted from seconds, all fields added
// linearly) and its ctd and ctp counters; each yields one result item with
// Unix seconds (mod 2^32), the fraction of the second in ns as
// floor(ctd * 1e9 / P) with P = ctp & 0x7fffffff (saturated at 2^32-1,
// zero with tuser low when P is zero), and seconds * 1e9 + ns mod 2^64.
// Throughput is one item per clock while the output is not stalled; the
// pipeline depth is set by the 32-stage restoring divider behind the
// ctd * 1e9 multiply and the overflow check. The whole pipeline advances
// together whenever the output register is empty or being taken.
module gps_date_to_unix_timestamp import gdut_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] second_field, [15:8] leap_seconds, [23:16] minute_field,
    // [31:24] hour_field, [39:32] day_field, [43:40] month_field,
    // [55:44] year_field, [87:56] ctd_count, [119:88] ctp_count
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] unix_seconds, [63:32] nanoseconds, [127:64] total_nanoseconds
    output logic [127:0] m_axis_tdata,
    // [0] fraction_valid
    output logic         m_axis_tuser
);

    localparam int DLY = DIV_LAT - CAL_LAT;

    logic          en;
    logic [31:0]   cal_secs;
    logic [63:0]   cal_sns;
    t_frac         frac;

    logic          r_vld   [0:DIV_LAT-1];
    logic [31:0]   r_dsecs [0:DLY-1];
    logic [63:0]   r_dsns  [0:DLY-1];
    logic          r_ovalid;
    logic [127:0]  r_odata;
    logic          r_ouser;

    // pipeline moves when the output slot is free or drains this cycle
    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    gdut_cal u_cal (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_second  (s_axis_tdata[7:0]),
        .i_leap    (s_axis_tdata[15:8]),
        .i_minute  (s_axis_tdata[23:16]),
        .i_hour    (s_axis_tdata[31:24]),
        .i_day     (s_axis_tdata[39:32]),
        .i_month   (s_axis_tdata[43:40]),
        .i_year    (s_axis_tdata[55:44]),
        .o_secs    (cal_secs),
        .o_secs_ns (cal_sns)
    );

    gdut_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ctd  (s_axis_tdata[87:56]),
        .i_ctp  (s_axis_tdata[119:88]),
        .o_frac (frac)
    );

    // valid bits riding alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_ovalid <= r_vld[DIV_LAT-1];
        end
    end

    // calendar result waits for the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsecs[0] <= cal_secs;
            r_dsns[0]  <= cal_sns;
            for (int i = 1; i < DLY; i++) begin
                r_dsecs[i] <= r_dsecs[i-1];
                r_dsns[i]  <= r_dsns[i-1];
            end
            r_odata <= {r_dsns[DLY-1] + 64'(frac.ns), frac.ns, r_dsecs[DLY-1]};
            r_ouser <= frac.valid;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

// ===== rtl/core/gdut_checker.sv =====
`timescale 1ns / 1ps
`include "gps_date_to_unix_timestamp_assert.svh"
module gdut_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [119:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    logic         out_stall;
    logic         no_frac;
    logic [129:0] out_word;
    logic [63:0]  want_total;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign no_frac    = m_axis_tvalid && !m_axis_tuser;
    assign out_word   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
    assign want_total = 64'(m_axis_tdata[31:0]) * 64'd1000000000 + 64'(m_axis_tdata[63:32]);

    `GDUT_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "output item changed while stalled")
    `GDUT_ASSERT_NOW(a_stall_blocks, out_stall, !s_axis_tready, "input taken while output stalled")
    `GDUT_ASSERT_NOW(a_zero_frac, no_frac, m_axis_tdata[63:32] == 32'd0, "ns nonzero, zero period")
    `GDUT_ASSERT_NOW(a_total, m_axis_tvalid, m_axis_tdata[127:64] == want_total, "total ns mismatch")

endmodule

bind gps_date_to_unix_timestamp gdut_checker u_gdut_checker (.*);
